FILE: hdl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Holds the payload structs, operation and status codes, and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic [1:0]         status;
    logic               last_result;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic op_en;       // apply a single-result transaction and load its result
    logic dump_start;  // latch walk pointer/count, read the front entry
    logic dump_emit;   // load one dumped entry, advance the walk
  } bdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic dump_last;   // the entry now read is the back entry
  } bdq_sts_t;

endpackage

FILE: hdl/bounded_deque_with_dump.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_dump: bounded double-ended queue with ordered dump
// Ring of DEPTH signed 32-bit entries; push/pop at either end, dump walks
// the entries front to back and flags the last one.
// ----------------------------------------------------------------------------
//
//   channel   ports                         payload  meaning
//   --------  ----------------------------  -------  -------------------------
//   input     in_valid / in_ready / in_data  in_t    one operation per item
//   result    out_valid/ out_ready/ out_data out_t   status, dumped entries
//
// Results: push, pop, unused codes and a dump of an empty store each give one
// result. A dump of N entries first issues the read of the front entry from the
// registered-read store, then gives one entry per cycle while the result side
// keeps up.
// Reset: synchronous on rst_n low; clears count, front pointer and control.
// Stalls: a held result (out_ready low) blocks new input and freezes the dump
// walk; the result register lets the next item in as the current one leaves.
// ----------------------------------------------------------------------------
module bounded_deque_with_dump #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bdq_pkg::out_t out_data
);
  import bdq_pkg::*;

  bdq_cmd_t cmd;
  bdq_sts_t sts;

  // Controller: decide per transaction, walk the dump one entry at a time.
  bdq_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_data.operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: ring store, pointers, result register.
  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // Only dumped entries may leave a result open (last_result low).
  a_open_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> out_data.status == ST_OK)
    else $error("non-final result with error status");

  // Error results carry no entry and always close the transaction.
  a_err_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.entry_value == '0 && out_data.last_result)
    else $error("error result with payload or open transaction");

  // A dump of a non-empty store blocks input on the next cycle.
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_DUMP && !sts.empty
      |=> !in_ready)
    else $error("input taken during dump walk");
`endif

endmodule

FILE: hdl/bdq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dp: deque datapath
// Ring store, front pointer, entry count, dump walk and result register.
// ----------------------------------------------------------------------------
module bdq_dp #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bdq_pkg::bdq_cmd_t cmd,
  input  bdq_pkg::in_t      in_data,
  output bdq_pkg::bdq_sts_t sts,
  output bdq_pkg::out_t     out_data
);
  import bdq_pkg::*;

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  logic [IDXW-1:0] front_r, front_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [IDXW-1:0] slot_r, slot_nxt;
  logic [CNTW-1:0] rem_r, rem_nxt;
  out_t            out_r, out_nxt;

  logic            full;
  logic            empty;
  logic [IDXW-1:0] front_dec;
  logic [IDXW-1:0] slot_inc;
  logic [IDXW:0]   back_sum;
  logic [IDXW-1:0] back_slot;
  logic            we;
  logic [IDXW-1:0] wr_addr;
  logic            re;
  logic [IDXW-1:0] rd_addr;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? IDXW'(DEPTH - 1) : front_r - 1'b1;
  assign slot_inc  = (slot_r == IDXW'(DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // Slot just past the back entry; count < DEPTH here, so one wrap suffices.
  assign back_sum  = {1'b0, front_r} + (IDXW + 1)'(count_r);
  assign back_slot = (back_sum >= (IDXW + 1)'(DEPTH)) ?
                     IDXW'(back_sum - (IDXW + 1)'(DEPTH)) : back_sum[IDXW-1:0];

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    slot_nxt  = slot_r;
    rem_nxt   = rem_r;
    out_nxt   = out_r;
    we        = 1'b0;
    wr_addr   = back_slot;
    re        = 1'b0;
    rd_addr   = front_r;

    if (cmd.op_en) begin
      out_nxt.entry_value = '0;
      out_nxt.status      = ST_OK;
      out_nxt.last_result = 1'b1;
      case (in_data.operation)
        OP_PUSH_FRONT: begin
          if (full) begin
            out_nxt.status = ST_OVERFLOW;
          end else begin
            front_nxt = front_dec;
            wr_addr   = front_dec;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            out_nxt.status = ST_OVERFLOW;
          end else begin
            wr_addr   = back_slot;
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            out_nxt.status = ST_UNDERFLOW;
          end else begin
            front_nxt = (front_r == IDXW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            out_nxt.status = ST_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_DUMP: begin
          // only an empty store dumps through here
          out_nxt.status = ST_UNDERFLOW;
        end
        default: begin
          out_nxt.status = ST_OK;
        end
      endcase
    end

    if (cmd.dump_start) begin
      slot_nxt = front_r;
      rem_nxt  = count_r;
      rd_addr  = front_r;
      re       = 1'b1;
    end

    if (cmd.dump_emit) begin
      out_nxt.entry_value = rd_data_r;
      out_nxt.status      = ST_OK;
      out_nxt.last_result = (rem_r == CNTW'(1));
      slot_nxt            = slot_inc;
      rem_nxt             = rem_r - 1'b1;
      rd_addr             = slot_inc;
      re                  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      slot_r  <= '0;
      rem_r   <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      slot_r  <= slot_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= in_data.push_value;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign sts.empty     = empty;
  assign sts.dump_last = (rem_r == CNTW'(1));
  assign out_data      = out_r;

endmodule

FILE: hdl/bdq_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctl: deque controller
// Sequences single-result transactions and the dump walk, owns both handshakes.
// ----------------------------------------------------------------------------
module bdq_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdq_pkg::bdq_sts_t sts,
  output bdq_pkg::bdq_cmd_t cmd
);
  import bdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd.op_en      = 1'b0;
    cmd.dump_start = 1'b0;
    cmd.dump_emit  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_DUMP && !sts.empty) begin
            cmd.dump_start = 1'b1;
            state_nxt      = S_DUMP;
          end else begin
            cmd.op_en     = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.dump_emit = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
